[sv/debounced_edge_rate_counter_macros.svh]
// Assertion macros for the checker file.
`ifndef DEBOUNCED_EDGE_RATE_COUNTER_MACROS_SVH
`define DEBOUNCED_EDGE_RATE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DERC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DERC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/derc_pkg.sv]
// Shared constants and controller/datapath interface types.
package derc_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

    localparam int RATE_SCALE    = 10000;
    localparam int NUM_W         = $clog2(RATE_SCALE * HISTORY_DEPTH + 1);
    localparam int QW            = (NUM_W > 16) ? NUM_W : 17;
    localparam int DCNT_W        = $clog2(NUM_W);

    localparam int TIME_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLING    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEVEL = 2'd3;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [15:0] RST_DEBOUNCE = 16'd50;
    localparam logic [15:0] RST_WINDOW   = 16'd1000;
    localparam logic        RST_FALLING  = 1'b1;
    localparam logic        RST_LEVEL    = 1'b1;
    localparam logic [15:0] SAT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic walk_step;
        logic walk_cmp;
        logic mul;
        logic div_step;
        logic fin;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_query;
        logic fill_zero;
        logic walk_done;
        logic div_done;
        logic out_free;
    } t_ctl_sts;

endpackage

[sv/debounced_edge_rate_counter.sv]
// Top level: debounced edge counter with sliding-window rate query.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_command, i_raw_level, i_now_ms
//   out       output     o_out_valid / i_out_stall  o_edge_counted, o_stable_now,
//                                                   o_hits, o_rate_x10
//   cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One word at a time. Sample, clear and unused commands, and a query on an empty
// ring, go from execute straight to output. Other queries walk k ring entries (one
// ring RAM read a cycle), then NUM_W = 18 divider steps, one quotient bit a cycle.
// Reset is synchronous; no clearing pass, the ring is only read where written.
// The output register holds a finished word under stall; the next word waits for it.
module debounced_edge_rate_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [derc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [derc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_command,
    input  logic                             i_raw_level,
    input  logic [derc_pkg::TIME_W-1:0]      i_now_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_edge_counted,
    output logic                             o_stable_now,
    output logic [15:0]                      o_hits,
    output logic [15:0]                      o_rate_x10
);

    derc_pkg::t_ctl_cmd ctl;
    derc_pkg::t_ctl_sts sts;

    derc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    derc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_raw_level    (i_raw_level),
        .i_now_ms       (i_now_ms),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_edge_counted (o_edge_counted),
        .o_stable_now   (o_stable_now),
        .o_hits         (o_hits),
        .o_rate_x10     (o_rate_x10)
    );

endmodule

[sv/derc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module derc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/derc_datapath.sv]
// Datapath: config, debounce state, edge ring, walk counter, divider, output word.
module derc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [derc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [derc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                       i_command,
    input  logic                             i_raw_level,
    input  logic [derc_pkg::TIME_W-1:0]      i_now_ms,
    input  derc_pkg::t_ctl_cmd               i_ctl,
    output derc_pkg::t_ctl_sts               o_sts,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic                             o_edge_counted,
    output logic                             o_stable_now,
    output logic [15:0]                      o_hits,
    output logic [15:0]                      o_rate_x10
);

    localparam int IDX_W  = derc_pkg::IDX_W;
    localparam int FILL_W = derc_pkg::FILL_W;
    localparam int NUM_W  = derc_pkg::NUM_W;
    localparam int QW     = derc_pkg::QW;
    localparam int DCNT_W = derc_pkg::DCNT_W;
    localparam int TIME_W = derc_pkg::TIME_W;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(derc_pkg::HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(derc_pkg::HISTORY_DEPTH);

    // configuration
    logic [15:0]       r_debounce;
    logic [15:0]       r_window;
    logic              r_falling;

    // latched input word
    logic [1:0]        r_cmd;
    logic              r_raw;
    logic [TIME_W-1:0] r_now;

    // debounce and hit state
    logic              r_stable;
    logic              r_last_raw;
    logic [TIME_W-1:0] r_chg_time;
    logic [15:0]       r_hits;
    logic [IDX_W-1:0]  r_head;
    logic [FILL_W-1:0] r_fill;
    logic              r_counted;

    // query walk and divider
    logic [IDX_W-1:0]  r_ptr;
    logic [FILL_W-1:0] r_n;
    logic [TIME_W-1:0] r_cutoff;
    logic [NUM_W-1:0]  r_quo;
    logic [15:0]       r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [15:0]       r_rate;

    // output word
    logic              r_out_valid;
    logic              r_o_counted;
    logic              r_o_stable;
    logic [15:0]       r_o_hits;
    logic [15:0]       r_o_rate;

    logic              dbc_elapsed;
    logic              edge_hit;
    logic              do_sample;
    logic              do_edge;
    logic [TIME_W-1:0] ram_q;
    logic              walk_ge;
    logic [16:0]       div_sh;
    logic [16:0]       div_diff;
    logic              div_ge;
    logic [QW-1:0]     quo_ext;
    logic [15:0]       rate_fin;

    assign dbc_elapsed = (r_now - r_chg_time) >= TIME_W'(r_debounce);
    assign edge_hit    = r_falling ? (r_stable & ~r_raw) : (~r_stable & r_raw);
    // a sample that holds its raw level, differs from stable and has outlasted the debounce
    assign do_sample   = i_ctl.exec && (r_cmd == derc_pkg::CMD_SAMPLE)
                         && (r_raw == r_last_raw) && (r_raw != r_stable) && dbc_elapsed;
    assign do_edge     = do_sample && edge_hit;

    derc_ram #(
        .WIDTH (TIME_W),
        .DEPTH (derc_pkg::HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (do_edge),
        .i_waddr (r_head),
        .i_wdata (r_now),
        .i_raddr (r_ptr),
        .o_rdata (ram_q)
    );

    assign walk_ge  = ram_q >= r_cutoff;

    assign div_sh   = {r_rem, r_quo[NUM_W-1]};
    assign div_diff = div_sh - {1'b0, r_window};
    assign div_ge   = div_sh >= {1'b0, r_window};

    assign quo_ext  = QW'(r_quo);

    always_comb begin
        if (r_window == 16'd0) begin
            rate_fin = (r_n != '0) ? derc_pkg::SAT_MAX : 16'd0;
        end else if (quo_ext > QW'(derc_pkg::SAT_MAX)) begin
            rate_fin = derc_pkg::SAT_MAX;
        end else begin
            rate_fin = 16'(quo_ext);
        end
    end

    // config registers; initial_level has no stored effect, reset always takes the default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= derc_pkg::RST_DEBOUNCE;
            r_window   <= derc_pkg::RST_WINDOW;
            r_falling  <= derc_pkg::RST_FALLING;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                derc_pkg::CFG_DEBOUNCE:   r_debounce <= i_cfg_data;
                derc_pkg::CFG_WINDOW:     r_window   <= i_cfg_data;
                derc_pkg::CFG_FALLING:    r_falling  <= i_cfg_data[0];
                derc_pkg::CFG_INIT_LEVEL: ;
                default: ;
            endcase
        end
    end

    // input latch and per-word flags
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd     <= i_command;
            r_raw     <= i_raw_level;
            r_now     <= i_now_ms;
            r_counted <= 1'b0;
            r_rate    <= 16'd0;
        end else begin
            if (do_edge) begin
                r_counted <= 1'b1;
            end
            if (i_ctl.fin) begin
                r_rate <= rate_fin;
            end
        end
    end

    // debounce state, hit total and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable   <= derc_pkg::RST_LEVEL;
            r_last_raw <= derc_pkg::RST_LEVEL;
            r_chg_time <= '0;
            r_hits     <= 16'd0;
            r_head     <= '0;
            r_fill     <= '0;
        end else if (i_ctl.exec) begin
            if (r_cmd == derc_pkg::CMD_SAMPLE) begin
                if (r_raw != r_last_raw) begin
                    r_last_raw <= r_raw;
                    r_chg_time <= r_now;
                end else if (do_sample) begin
                    r_stable <= r_raw;
                end
                if (do_edge) begin
                    if (r_hits != derc_pkg::SAT_MAX) begin
                        r_hits <= r_hits + 16'd1;
                    end
                    r_head <= (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
                    if (r_fill != FILL_MAX) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end else if (r_cmd == derc_pkg::CMD_CLEAR) begin
                r_hits <= 16'd0;
                r_head <= '0;
                r_fill <= '0;
            end
        end
    end

    // ring walk, newest first; read data is registered, so it lags the pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_ptr    <= (r_head == '0) ? IDX_LAST : r_head - 1'b1;
            r_n      <= '0;
            r_cutoff <= r_now - TIME_W'(r_window);
        end else begin
            if (i_ctl.walk_step) begin
                r_ptr <= (r_ptr == '0) ? IDX_LAST : r_ptr - 1'b1;
            end
            if (i_ctl.walk_cmp && walk_ge) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_quo  <= NUM_W'(r_n * derc_pkg::RATE_SCALE);
            r_rem  <= 16'd0;
            r_dcnt <= '0;
        end else if (i_ctl.div_step) begin
            r_quo  <= {r_quo[NUM_W-2:0], div_ge};
            r_rem  <= div_ge ? div_diff[15:0] : div_sh[15:0];
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_o_counted <= r_counted;
            r_o_stable  <= r_stable;
            r_o_hits    <= r_hits;
            r_o_rate    <= r_rate;
        end
    end

    assign o_sts.is_query  = (r_cmd == derc_pkg::CMD_QUERY);
    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.walk_done = !walk_ge || (FILL_W'(r_n + 1'b1) == r_fill);
    assign o_sts.div_done  = (r_dcnt == DCNT_W'(NUM_W - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_edge_counted = r_o_counted;
    assign o_stable_now   = r_o_stable;
    assign o_hits         = r_o_hits;
    assign o_rate_x10     = r_o_rate;

endmodule

[sv/derc_ctrl.sv]
// Controller: sequences one word through execute, ring walk, divide and output.
module derc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  derc_pkg::t_ctl_sts i_sts,
    output derc_pkg::t_ctl_cmd o_ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                // empty ring answers zero straight away
                n_state = (i_sts.is_query && !i_sts.fill_zero) ? S_RD : S_DONE;
            end
            S_RD: begin
                o_ctl.walk_step = 1'b1;
                n_state         = S_CMP;
            end
            S_CMP: begin
                o_ctl.walk_step = 1'b1;
                o_ctl.walk_cmp  = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_ctl.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[sv/derc_checker.sv]
// Port-level checker for the top level, bound in below.
`include "debounced_edge_rate_counter_macros.svh"

module derc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [derc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [derc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [1:0]                       i_command,
    input logic                             i_raw_level,
    input logic [derc_pkg::TIME_W-1:0]      i_now_ms,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic                             o_edge_counted,
    input logic                             o_stable_now,
    input logic [15:0]                      o_hits,
    input logic [15:0]                      o_rate_x10
);

    // one word in flight: an accepted word closes the input for the next cycle
    `DERC_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall, "second word accepted while busy")

    // a counted edge always leaves a non-zero hit total
    `DERC_ASSERT_NOW(a_edge_hits, o_out_valid && o_edge_counted, o_hits != 16'd0, "edge counted with zero hits")

    // a word with a counted edge (a sample word) never carries a rate
    `DERC_ASSERT_NOW(a_edge_no_rate, o_out_valid && o_edge_counted, o_rate_x10 == 16'd0, "rate on a counted edge")

    // a stalled output word holds
    `DERC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_hits) && $stable(o_rate_x10), "stalled output word changed")

endmodule

bind debounced_edge_rate_counter derc_checker u_derc_checker (.*);
